[rtl/lpmr_pkg.sv]
// Shared types and codes for the length-prefixed message ring.
package lpmr_pkg;

    // Operation codes carried by the op field
    localparam logic [2:0] OP_PUSH_START = 3'd0;
    localparam logic [2:0] OP_PUSH_BYTE  = 3'd1;
    localparam logic [2:0] OP_PEEK_START = 3'd2;
    localparam logic [2:0] OP_PEEK_BYTE  = 3'd3;
    localparam logic [2:0] OP_POP        = 3'd4;

    // Result status codes
    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_EMPTY      = 3'd1;
    localparam logic [2:0] STAT_NEVER_FITS = 3'd2;
    localparam logic [2:0] STAT_TOO_LONG   = 3'd3;
    localparam logic [2:0] STAT_SEQUENCE   = 3'd4;

    // Message header is a two-byte little-endian length
    localparam int         HDR_BYTES = 2;
    localparam logic [7:0] BYTE_MASK = 8'hFF;
    localparam logic [8:0] EV_MAX    = 9'd511;

    // Controller sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVICT,
        S_HDR_B,
        S_HDR_C,
        S_PUT_HI,
        S_BYTE
    } state_t;

    // One result beat
    typedef struct packed {
        logic [2:0] status;
        logic [9:0] head_length;
        logic [7:0] byte_out;
        logic       last_byte;
        logic [8:0] evicted;
    } res_t;

endpackage

[rtl/lpmr_core.sv]
// Ring controller: byte memory, pointers and the operation sequencer.
module lpmr_core #(
    parameter int CAPACITY = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        op,
    input  logic [9:0]        message_length,
    input  logic [7:0]        payload_byte,
    input  logic [9:0]        reader_limit,
    output logic              res_valid,
    input  logic              res_ready,
    output lpmr_pkg::res_t    res
);
    import lpmr_pkg::*;

    localparam int PTR_W  = $clog2(CAPACITY);
    localparam int USED_W = $clog2(CAPACITY + 1);
    localparam int MSG_W  = $clog2(CAPACITY / 2 + 1);
    localparam int SUM_W  = ((USED_W > 11) ? USED_W : 11) + 1;
    localparam logic [SUM_W-1:0] CAP_S = SUM_W'(CAPACITY);
    localparam logic [SUM_W-1:0] TWO_S = SUM_W'(HDR_BYTES);
    localparam logic [SUM_W-1:0] ONE_S = SUM_W'(1);

    // Modular add of an offset no larger than the capacity
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] pos,
                                                  input logic [SUM_W-1:0] n);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(pos) + n;
        if (sum >= CAP_S)
            sum = sum - CAP_S;
        return sum[PTR_W-1:0];
    endfunction

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [USED_W-1:0]  used_reg, used_next;
    logic [MSG_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wcur_reg, wcur_next;
    logic [9:0]         wrem_reg, wrem_next;
    logic               wact_reg, wact_next;
    logic [PTR_W-1:0]   rcur_reg, rcur_next;
    logic [9:0]         rrem_reg, rrem_next;
    logic [8:0]         ev_reg, ev_next;
    logic [2:0]         op_reg, op_next;
    logic [9:0]         len_reg, len_next;
    logic [9:0]         limit_reg, limit_next;
    logic [7:0]         hdr_lo_reg, hdr_lo_next;
    logic [7:0]         mem_q_reg;

    logic [7:0]         ring_mem [CAPACITY];
    logic               mem_we;
    logic [PTR_W-1:0]   wr_addr;
    logic [7:0]         wr_data;
    logic [PTR_W-1:0]   rd_addr;

    logic               in_fire;
    logic [SUM_W-1:0]   tot_in;
    logic [SUM_W-1:0]   tot_push;
    logic [SUM_W-1:0]   free_bytes;
    logic               need_evict;
    logic [9:0]         hdr_len;
    logic [15:0]        hdr_full;
    logic [SUM_W-1:0]   drop_tot;
    logic               byte_ok;

    assign in_ready   = (state_reg == S_IDLE) && res_ready;
    assign in_fire    = in_valid && in_ready;
    assign tot_in     = SUM_W'(message_length) + TWO_S;
    assign tot_push   = SUM_W'(len_reg) + TWO_S;
    assign free_bytes = CAP_S - SUM_W'(used_reg);
    assign need_evict = (free_bytes < tot_push) && (count_reg != '0);
    assign hdr_full   = {mem_q_reg, hdr_lo_reg};
    assign hdr_len    = {mem_q_reg[1:0], hdr_lo_reg};
    assign byte_ok    = wact_reg && (wrem_reg != 10'd0);

    // Bytes freed by dropping the head, clamped to what is in use
    always_comb
    begin
        drop_tot = TWO_S + SUM_W'(hdr_len);
        if (drop_tot > SUM_W'(used_reg))
            drop_tot = SUM_W'(used_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (op)
                        OP_PUSH_START:
                            if (!wact_reg && (tot_in <= CAP_S))
                                state_next = S_EVICT;
                        OP_PEEK_START, OP_POP:
                            if (count_reg != '0)
                                state_next = S_HDR_B;
                        OP_PEEK_BYTE:
                            if (rrem_reg != 10'd0)
                                state_next = S_BYTE;
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_EVICT:  state_next = need_evict ? S_HDR_B : S_PUT_HI;
            S_HDR_B:  state_next = S_HDR_C;
            S_HDR_C:  state_next = (op_reg == OP_PUSH_START) ? S_EVICT : S_IDLE;
            S_PUT_HI: state_next = S_IDLE;
            S_BYTE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs: result beat and memory port controls
    always_comb
    begin
        res_valid = 1'b0;
        res       = '0;
        mem_we    = 1'b0;
        wr_addr   = wcur_reg;
        wr_data   = payload_byte;
        rd_addr   = head_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (op == OP_PEEK_BYTE)
                    rd_addr = rcur_reg;
                if (in_fire)
                begin
                    case (op)
                        OP_PUSH_START:
                        begin
                            if (wact_reg)
                            begin
                                res_valid  = 1'b1;
                                res.status = STAT_SEQUENCE;
                            end
                            else if (tot_in > CAP_S)
                            begin
                                res_valid  = 1'b1;
                                res.status = STAT_NEVER_FITS;
                            end
                        end
                        OP_PUSH_BYTE:
                        begin
                            res_valid  = 1'b1;
                            res.status = byte_ok ? STAT_OK : STAT_SEQUENCE;
                            mem_we     = byte_ok;
                        end
                        OP_PEEK_START, OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_valid  = 1'b1;
                                res.status = STAT_EMPTY;
                            end
                        end
                        OP_PEEK_BYTE:
                        begin
                            if (rrem_reg == 10'd0)
                            begin
                                res_valid  = 1'b1;
                                res.status = STAT_SEQUENCE;
                            end
                        end
                        default:
                        begin
                            res_valid  = 1'b1;
                            res.status = STAT_SEQUENCE;
                        end
                    endcase
                end
            end
            S_EVICT:
            begin
                // Header low byte goes out once there is room
                if (!need_evict)
                begin
                    mem_we  = 1'b1;
                    wr_addr = tail_reg;
                    wr_data = len_reg[7:0] & BYTE_MASK;
                end
            end
            S_HDR_B:
                rd_addr = ring_add(head_reg, ONE_S);
            S_HDR_C:
            begin
                if (op_reg == OP_PEEK_START)
                begin
                    res_valid       = 1'b1;
                    res.head_length = hdr_full[9:0];
                    res.status      = (hdr_full > {6'd0, limit_reg}) ? STAT_TOO_LONG
                                                                     : STAT_OK;
                end
                else if (op_reg == OP_POP)
                begin
                    res_valid  = 1'b1;
                    res.status = STAT_OK;
                end
            end
            S_PUT_HI:
            begin
                mem_we      = 1'b1;
                wr_addr     = ring_add(tail_reg, ONE_S);
                wr_data     = {6'd0, len_reg[9:8]};
                res_valid   = 1'b1;
                res.status  = STAT_OK;
                res.evicted = ev_reg;
            end
            S_BYTE:
            begin
                res_valid     = 1'b1;
                res.status    = STAT_OK;
                res.byte_out  = mem_q_reg;
                res.last_byte = (rrem_reg == 10'd1);
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Pointer, counter and cursor updates
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        used_next   = used_reg;
        count_next  = count_reg;
        wcur_next   = wcur_reg;
        wrem_next   = wrem_reg;
        wact_next   = wact_reg;
        rcur_next   = rcur_reg;
        rrem_next   = rrem_reg;
        ev_next     = ev_reg;
        op_next     = op_reg;
        len_next    = len_reg;
        limit_next  = limit_reg;
        hdr_lo_next = hdr_lo_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next    = op;
                    limit_next = reader_limit;
                    case (op)
                        OP_PUSH_START:
                        begin
                            if (!wact_reg && (tot_in <= CAP_S))
                            begin
                                len_next = message_length;
                                ev_next  = '0;
                            end
                        end
                        OP_PUSH_BYTE:
                        begin
                            if (byte_ok)
                            begin
                                wcur_next = ring_add(wcur_reg, ONE_S);
                                wrem_next = wrem_reg - 10'd1;
                                // Last byte commits the message
                                if (wrem_reg == 10'd1)
                                begin
                                    tail_next  = ring_add(wcur_reg, ONE_S);
                                    used_next  = USED_W'(SUM_W'(used_reg) + tot_push);
                                    count_next = count_reg + MSG_W'(1);
                                    wact_next  = 1'b0;
                                end
                            end
                        end
                        OP_PEEK_START, OP_POP:
                            rrem_next = 10'd0;
                        default:
                            rrem_next = rrem_reg;
                    endcase
                end
            end
            S_HDR_B:
                hdr_lo_next = mem_q_reg;
            S_HDR_C:
            begin
                if (op_reg == OP_PEEK_START)
                begin
                    if (hdr_full <= {6'd0, limit_reg})
                    begin
                        rcur_next = ring_add(head_reg, TWO_S);
                        rrem_next = hdr_len;
                    end
                end
                else
                begin
                    // Drop the head message (pop or eviction)
                    head_next  = ring_add(head_reg, drop_tot);
                    used_next  = USED_W'(SUM_W'(used_reg) - drop_tot);
                    count_next = count_reg - MSG_W'(1);
                    if (op_reg == OP_PUSH_START)
                    begin
                        rrem_next = 10'd0;
                        if (ev_reg != EV_MAX)
                            ev_next = ev_reg + 9'd1;
                    end
                end
            end
            S_PUT_HI:
            begin
                wcur_next = ring_add(tail_reg, TWO_S);
                wrem_next = len_reg;
                wact_next = 1'b1;
                // Empty message commits with its header
                if (len_reg == 10'd0)
                begin
                    tail_next  = ring_add(tail_reg, TWO_S);
                    used_next  = USED_W'(SUM_W'(used_reg) + TWO_S);
                    count_next = count_reg + MSG_W'(1);
                    wact_next  = 1'b0;
                end
            end
            S_BYTE:
            begin
                rcur_next = ring_add(rcur_reg, ONE_S);
                rrem_next = rrem_reg - 10'd1;
            end
            default:
            begin
                head_next = head_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            used_reg  <= '0;
            count_reg <= '0;
            wcur_reg  <= '0;
            wrem_reg  <= '0;
            wact_reg  <= 1'b0;
            rcur_reg  <= '0;
            rrem_reg  <= '0;
            ev_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            used_reg  <= used_next;
            count_reg <= count_next;
            wcur_reg  <= wcur_next;
            wrem_reg  <= wrem_next;
            wact_reg  <= wact_next;
            rcur_reg  <= rcur_next;
            rrem_reg  <= rrem_next;
            ev_reg    <= ev_next;
        end
    end

    // Item payload latches
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        len_reg    <= len_next;
        limit_reg  <= limit_next;
        hdr_lo_reg <= hdr_lo_next;
    end

    // Byte ring: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[wr_addr] <= wr_data;
        mem_q_reg <= ring_mem[rd_addr];
    end

    // An open push always has payload bytes outstanding
    assert property (@(posedge clk) disable iff (!rst_n)
        wact_reg |-> (wrem_reg != 10'd0))
        else $error("open push with no bytes left");

    // Fill level never exceeds the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(used_reg) <= CAP_S)
        else $error("ring fill beyond capacity");

    // Bytes are in use exactly when messages are stored
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (used_reg == '0))
        else $error("fill level and message count disagree");

    // A header is only fetched when a message is stored
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HDR_C) |-> (count_reg != '0))
        else $error("header fetch from an empty ring");

endmodule

[rtl/lpmr_out_stage.sv]
// Result output register with one skid entry behind it.
module lpmr_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    output logic              res_ready,
    input  lpmr_pkg::res_t    res,
    output logic              out_valid,
    input  logic              out_ready,
    output lpmr_pkg::res_t    out_res
);
    import lpmr_pkg::*;

    logic  out_valid_reg, out_valid_next;
    logic  skid_valid_reg, skid_valid_next;
    res_t  out_res_reg, out_res_next;
    res_t  skid_res_reg, skid_res_next;
    logic  out_pop;

    assign out_pop   = out_valid_reg && out_ready;
    assign res_ready = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // Output and skid occupancy
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_valid)
        begin
            if (!out_valid_reg || out_pop)
            begin
                out_res_next   = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_res_next   = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    // Skid only fills behind a waiting output beat
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output beat");

    // Controller never finishes an item into a full stage
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_ready)
        else $error("result dropped at full output stage");

endmodule

[rtl/length_prefixed_message_ring.sv]
// Top level of the length-prefixed message ring with overwrite of the oldest messages.
//
// Messages live in one CAPACITY-byte ring memory as a two-byte little-endian length
// followed by the payload; every input beat yields exactly one result beat. Push byte
// is handled without leaving the idle state; peek byte makes one registered memory
// read; peek start and pop make two header byte reads; push start walks one header
// through the single memory read port for each message it evicts, then writes the
// two header bytes. Input is held off only while the controller works on an item or
// while two results wait at the output. The ring needs no clearing after reset.
module length_prefixed_message_ring #(
    parameter int CAPACITY = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] op,
    input  logic [9:0] message_length,
    input  logic [7:0] payload_byte,
    input  logic [9:0] reader_limit,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [9:0] head_length,
    output logic [7:0] byte_out,
    output logic       last_byte,
    output logic [8:0] evicted
);
    import lpmr_pkg::*;

    logic  res_valid;
    logic  res_ready;
    res_t  res;
    res_t  out_res;

    lpmr_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .message_length (message_length),
        .payload_byte   (payload_byte),
        .reader_limit   (reader_limit),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    lpmr_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    // Result beat fields
    assign status      = out_res.status;
    assign head_length = out_res.head_length;
    assign byte_out    = out_res.byte_out;
    assign last_byte   = out_res.last_byte;
    assign evicted     = out_res.evicted;

endmodule

[dv/lpmr_checker.sv]
`timescale 1ns / 100ps
// Result checker for the message ring: predicts every beat and compares each result.
module lpmr_checker #(
    parameter int CAPACITY = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [2:0] op,
    input  logic [9:0] message_length,
    input  logic [7:0] payload_byte,
    input  logic [9:0] reader_limit,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [2:0] status,
    input  logic [9:0] head_length,
    input  logic [7:0] byte_out,
    input  logic       last_byte,
    input  logic [8:0] evicted,
    output int         fail_count,
    output int         results_owed
);
    import lpmr_pkg::*;

    // Shadow copy of the ring
    logic [7:0] msg_mem [CAPACITY];
    int         head_at;
    int         tail_at;
    int         used_bytes;
    int         n_msgs;
    int         wr_at;
    int         wr_left;
    bit         wr_open;
    int         rd_at;
    int         rd_left;

    res_t       awaited_results [$];
    res_t       want;

    function automatic int wrap(input int p, input int n);
        int s;
        s = p + n;
        if (s >= CAPACITY)
        begin
            s -= CAPACITY;
        end
        return s;
    endfunction

    // Little-endian length header at a ring position
    function automatic int header_at(input int p);
        return int'({msg_mem[wrap(p, 1)], msg_mem[p]});
    endfunction

    function automatic void drop_oldest();
        int span;
        if (n_msgs == 0)
        begin
            return;
        end
        span = HDR_BYTES + header_at(head_at);
        if (span > used_bytes)
        begin
            span = used_bytes;
        end
        head_at = (head_at + span) % CAPACITY;
        used_bytes -= span;
        n_msgs--;
    endfunction

    // Message becomes visible once its last byte is in
    function automatic void seal_message();
        used_bytes += HDR_BYTES + header_at(tail_at);
        tail_at = wr_at;
        n_msgs++;
        wr_open = 1'b0;
    endfunction

    // Expected result of one input beat; advances the shadow state
    function automatic res_t ring_response(input logic [2:0] code, input logic [9:0] mlen,
                                           input logic [7:0] pbyte, input logic [9:0] limit);
        res_t r;
        int   need;
        int   hlen;
        r = '0;
        r.status = STAT_SEQUENCE;
        case (code)
            OP_PUSH_START:
            begin
                need = HDR_BYTES + int'(mlen);
                if (!wr_open && need > CAPACITY)
                begin
                    r.status = STAT_NEVER_FITS;
                end
                else if (!wr_open)
                begin
                    // make room by dropping whole messages from the head
                    while (CAPACITY - used_bytes < need && n_msgs != 0)
                    begin
                        drop_oldest();
                        if (r.evicted < EV_MAX)
                        begin
                            r.evicted++;
                        end
                        rd_left = 0;
                    end
                    msg_mem[tail_at] = mlen[7:0] & BYTE_MASK;
                    msg_mem[wrap(tail_at, 1)] = {6'b0, mlen[9:8]};
                    wr_at = wrap(tail_at, HDR_BYTES);
                    wr_left = int'(mlen);
                    wr_open = 1'b1;
                    if (mlen == 0)
                    begin
                        seal_message();
                    end
                    r.status = STAT_OK;
                end
            end
            OP_PUSH_BYTE:
            begin
                if (wr_open && wr_left != 0)
                begin
                    msg_mem[wr_at] = pbyte;
                    wr_at = wrap(wr_at, 1);
                    wr_left--;
                    if (wr_left == 0)
                    begin
                        seal_message();
                    end
                    r.status = STAT_OK;
                end
            end
            OP_PEEK_START:
            begin
                rd_left = 0;
                if (n_msgs == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    hlen = header_at(head_at);
                    r.head_length = 10'(hlen);
                    if (hlen > int'(limit))
                    begin
                        r.status = STAT_TOO_LONG;
                    end
                    else
                    begin
                        rd_at = wrap(head_at, HDR_BYTES);
                        rd_left = hlen;
                        r.status = STAT_OK;
                    end
                end
            end
            OP_PEEK_BYTE:
            begin
                if (rd_left != 0)
                begin
                    r.byte_out = msg_mem[rd_at];
                    rd_at = wrap(rd_at, 1);
                    rd_left--;
                    r.last_byte = (rd_left == 0);
                    r.status = STAT_OK;
                end
            end
            OP_POP:
            begin
                rd_left = 0;
                if (n_msgs == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    drop_oldest();
                    r.status = STAT_OK;
                end
            end
            default:
            begin
                // unused codes leave everything alone
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [9:0] exp_val,
                                        input logic [9:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            fail_count++;
        end
    endfunction

    // Compare result beats first, then queue the prediction for a new input beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                msg_mem[i] = '0;
            end
            head_at = 0;
            tail_at = 0;
            used_bytes = 0;
            n_msgs = 0;
            wr_at = 0;
            wr_left = 0;
            wr_open = 1'b0;
            rd_at = 0;
            rd_left = 0;
            awaited_results.delete();
            fail_count = 0;
            results_owed <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result beat with no input beat waiting for it");
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("status", 10'(want.status), 10'(status));
                    check_field("head_length", want.head_length, head_length);
                    check_field("byte_out", 10'(want.byte_out), 10'(byte_out));
                    check_field("last_byte", 10'(want.last_byte), 10'(last_byte));
                    check_field("evicted", 10'(want.evicted), 10'(evicted));
                end
            end
            if (in_valid && in_ready)
            begin
                awaited_results.push_back(ring_response(op, message_length, payload_byte,
                                                        reader_limit));
            end
            results_owed <= awaited_results.size();
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// Top of the message ring testbench: clock, reset, stimulus and verdict.
module testbench;
    import lpmr_pkg::*;

    localparam int RING_BYTES = 1024;
    localparam int LIMIT_MAX = 1023;
    localparam int LEN_NEVER_FITS = 1023;
    localparam logic [2:0] OP_FIRST_UNUSED = OP_POP + 3'd1;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [2:0] op = OP_POP;
    logic [9:0] message_length = '0;
    logic [7:0] payload_byte = '0;
    logic [9:0] reader_limit = '0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [2:0] status;
    logic [9:0] head_length;
    logic [7:0] byte_out;
    logic       last_byte;
    logic [8:0] evicted;
    int         fail_count;
    int         results_owed;

    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         beats_sent = 0;

    // Stimulus-side view of the ring: lengths of stored messages and open streams
    int         stored_len [$];
    int         ring_fill = 0;
    bit         writing = 1'b0;
    int         open_len = 0;
    int         write_left = 0;
    int         stream_left = 0;

    always #2 clk = ~clk;

    length_prefixed_message_ring #(
        .CAPACITY(RING_BYTES)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .message_length(message_length),
        .payload_byte(payload_byte),
        .reader_limit(reader_limit),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .head_length(head_length),
        .byte_out(byte_out),
        .last_byte(last_byte),
        .evicted(evicted)
    );

    lpmr_checker #(
        .CAPACITY(RING_BYTES)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .message_length(message_length),
        .payload_byte(payload_byte),
        .reader_limit(reader_limit),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .head_length(head_length),
        .byte_out(byte_out),
        .last_byte(last_byte),
        .evicted(evicted),
        .fail_count(fail_count),
        .results_owed(results_owed)
    );

    // Receiver stalls at random
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Run limit
    initial
    begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic void close_write();
        stored_len.push_back(open_len);
        ring_fill += 2 + open_len;
        writing = 1'b0;
    endfunction

    // Track what an accepted beat does to message lengths and streams
    function automatic void note_beat(input logic [2:0] code, input int val);
        case (code)
            OP_PUSH_START:
            begin
                if (!writing && val <= RING_BYTES - 2)
                begin
                    while (RING_BYTES - ring_fill < val + 2 && stored_len.size() != 0)
                    begin
                        ring_fill -= 2 + stored_len.pop_front();
                        stream_left = 0;
                    end
                    open_len = val;
                    write_left = val;
                    writing = 1'b1;
                    if (val == 0)
                    begin
                        close_write();
                    end
                end
            end
            OP_PUSH_BYTE:
            begin
                if (writing && write_left != 0)
                begin
                    write_left--;
                    if (write_left == 0)
                    begin
                        close_write();
                    end
                end
            end
            OP_PEEK_START:
            begin
                stream_left = (stored_len.size() != 0 && stored_len[0] <= val) ? stored_len[0] : 0;
            end
            OP_PEEK_BYTE:
            begin
                if (stream_left != 0)
                begin
                    stream_left--;
                end
            end
            OP_POP:
            begin
                stream_left = 0;
                if (stored_len.size() != 0)
                begin
                    ring_fill -= 2 + stored_len.pop_front();
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // One input beat; fields the op does not use carry random values
    task automatic send_beat(input logic [2:0] code, input int val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= code;
        message_length <= (code == OP_PUSH_START) ? 10'(val) : 10'($urandom);
        payload_byte <= (code == OP_PUSH_BYTE) ? 8'(val) : 8'($urandom);
        reader_limit <= (code == OP_PEEK_START) ? 10'(val) : 10'($urandom);
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        note_beat(code, val);
        beats_sent++;
    endtask

    // Hold off the sender until every result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (results_owed != 0);
    endtask

    // Mostly short messages, some empty, a few long
    function automatic int message_size();
        int r;
        r = $urandom_range(99);
        if (r < 2)
        begin
            return $urandom_range(200, RING_BYTES - 2);
        end
        else if (r < 12)
        begin
            return 0;
        end
        return $urandom_range(1, 24);
    endfunction

    // Push start and the payload, with stray beats mixed in now and then
    task automatic push_message(input int len, input int mix_pct);
        send_beat(OP_PUSH_START, len);
        while (writing)
        begin
            if ($urandom_range(99) < mix_pct)
            begin
                case ($urandom_range(3))
                    0: send_beat(OP_PUSH_START, message_size());
                    1: send_beat(OP_PEEK_START, LIMIT_MAX);
                    2: send_beat(OP_PEEK_BYTE, 0);
                    default: send_beat(OP_POP, 0);
                endcase
            end
            send_beat(OP_PUSH_BYTE, $urandom_range(0, 255));
        end
    endtask

    // Peek start and stream; sometimes cut short by a pop or an evicting push
    task automatic read_message();
        int head;
        int lim;
        int n;
        int r;
        head = (stored_len.size() != 0) ? stored_len[0] : 0;
        r = $urandom_range(99);
        if (r < 65)
        begin
            lim = LIMIT_MAX;
        end
        else if (r < 80)
        begin
            lim = (head != 0) ? $urandom_range(0, head - 1) : 0;
        end
        else if (r < 90)
        begin
            lim = head;
        end
        else
        begin
            lim = $urandom_range(0, LIMIT_MAX);
        end
        send_beat(OP_PEEK_START, lim);
        n = stream_left;
        if ($urandom_range(99) < 15 && n > 1)
        begin
            repeat ($urandom_range(1, n - 1)) send_beat(OP_PEEK_BYTE, 0);
            if ($urandom_range(1) != 0)
            begin
                send_beat(OP_POP, 0);
            end
            else
            begin
                push_message(message_size(), 0);
            end
            send_beat(OP_PEEK_BYTE, 0);
        end
        else
        begin
            repeat (n) send_beat(OP_PEEK_BYTE, 0);
            if ($urandom_range(99) < 20)
            begin
                send_beat(OP_PEEK_BYTE, 0);
            end
        end
        if ($urandom_range(99) < 60)
        begin
            send_beat(OP_POP, 0);
        end
    endtask

    // Beats that are out of sequence, unused codes, oversized pushes or peek starts with random limits
    task automatic noise_beat();
        case ($urandom_range(4))
            0: send_beat(OP_PUSH_BYTE, $urandom_range(0, 255));
            1: send_beat(OP_PEEK_BYTE, 0);
            2: send_beat(OP_FIRST_UNUSED + 3'($urandom_range(0, 2)), $urandom);
            3: send_beat(OP_PUSH_START, LEN_NEVER_FITS);
            default: send_beat(OP_PEEK_START, $urandom_range(0, LIMIT_MAX));
        endcase
    endtask

    task automatic random_phase(input int beats);
        int stop_at;
        int pick;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                push_message(message_size(), 8);
            end
            else if (pick < 70)
            begin
                read_message();
            end
            else if (pick < 82)
            begin
                send_beat(OP_POP, 0);
            end
            else
            begin
                noise_beat();
            end
        end
    endtask

    // Empty the ring, fill it with empty messages, push one that needs the whole ring, then peek and pop it
    task automatic evict_everything();
        while (stored_len.size() != 0)
        begin
            send_beat(OP_POP, 0);
        end
        repeat (RING_BYTES / 2) send_beat(OP_PUSH_START, 0);
        push_message(RING_BYTES - 2, 0);
        send_beat(OP_PEEK_START, RING_BYTES - 3);
        send_beat(OP_PEEK_START, RING_BYTES - 2);
        repeat (5) send_beat(OP_PEEK_BYTE, 0);
        send_beat(OP_POP, 0);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 11;
        recv_idle_pct = 68;

        // Directed: empty ring, stray beats, unused codes, boundaries
        send_beat(OP_PEEK_START, LIMIT_MAX);
        send_beat(OP_POP, 0);
        send_beat(OP_PEEK_BYTE, 0);
        send_beat(OP_PUSH_BYTE, 8'hFF);
        for (int k = 0; k < 3; k++)
        begin
            send_beat(OP_FIRST_UNUSED + 3'(k), $urandom);
        end
        send_beat(OP_PUSH_START, LEN_NEVER_FITS);
        send_beat(OP_PUSH_START, 0);
        send_beat(OP_PEEK_START, 0);
        send_beat(OP_PEEK_BYTE, 0);
        send_beat(OP_PUSH_START, 3);
        send_beat(OP_PUSH_START, 5);
        send_beat(OP_PUSH_BYTE, 8'h00);
        send_beat(OP_PUSH_BYTE, 8'hFF);
        send_beat(OP_PUSH_BYTE, 8'hA5);
        send_beat(OP_POP, 0);
        send_beat(OP_PEEK_START, 2);
        send_beat(OP_PEEK_START, LIMIT_MAX);
        repeat (4) send_beat(OP_PEEK_BYTE, 0);
        send_beat(OP_POP, 0);

        random_phase(75);
        drain();

        send_idle_pct = 68;
        recv_idle_pct = 11;
        random_phase(75);
        drain();
        evict_everything();
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(75);
        drain();
        repeat (20) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
